// ===== rtl/sfpc_pkg.sv =====
// Shared types and constants for the sample frame packer.
// No dependencies; imported by every module of the block.
package sfpc_pkg;

    localparam int unsigned NUM_CH      = 8;
    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned COUNT_W     = 4;
    localparam int unsigned CRC_W       = 16;
    // Byte position in a frame: up to 2*8 + 3 = 19 bytes.
    localparam int unsigned POS_W       = 5;
    localparam int unsigned CH_IDX_W    = 3;

    localparam logic [CRC_W-1:0]   CRC_INIT      = 16'hFFFF;
    localparam logic [CRC_W-1:0]   CRC_POLY      = 16'hA001;
    localparam logic [COUNT_W-1:0] COUNT_RESET   = 4'd8;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [CRC_W-1:0]    crc_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [POS_W-1:0]    pos_t;

endpackage

// ===== rtl/sfpc_crc_step.sv =====
// One byte of CRC-16/MODBUS: reflected polynomial, low bit first.
// Depends on sfpc_pkg.
module sfpc_crc_step (
    input  sfpc_pkg::crc_t  crc_in,
    input  sfpc_pkg::byte_t data_in,
    output sfpc_pkg::crc_t  crc_out
);
    import sfpc_pkg::*;

    always_comb begin
        crc_t c;
        c = crc_in ^ {8'h00, data_in};
        for (int b = 0; b < BYTE_W; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

// ===== rtl/sample_frame_packer_crc16_unit.sv =====
// Top level of the sample frame packer: input hold register, byte sequencer,
// running CRC and output register. Depends on sfpc_pkg and sfpc_crc_step.
//
// Usage:
//   The s_ channel takes one conversion set (eight 16-bit samples) per
//   transaction. The m_ channel delivers the frame one byte per transaction:
//   count byte, then high and low byte of each active channel from channel 0
//   upward, then the inverted CRC-16/MODBUS low byte and high byte.
//   m_frame_end marks the last byte. A frame of n channels has 2n+3 bytes.
//   The cfg channel writes channel_count (0 reads as 1, above MAX_CHANNELS
//   as MAX_CHANNELS); it is sampled when a set is accepted and is always
//   ready. Write it only while the block is idle.
//   The count byte moves from the held set through the output register to m_.
//   The sequencer emits one frame byte per cycle unless the receiver stalls;
//   the byte sequencer is the limit, and the next set is taken in the cycle
//   the last byte of the current frame moves into the output register.
//   Reset (aresetn low, synchronous) empties the output register, drops the
//   held set and returns channel_count to 8.
//   When the receiver stalls, the output byte holds and the sequencer waits.
module sample_frame_packer_crc16_unit #(
    parameter int unsigned MAX_CHANNELS = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  sfpc_pkg::count_t cfg_channel_count,
    input  logic             s_valid,
    output logic             s_ready,
    input  sfpc_pkg::sample_t s_sample_ch0,
    input  sfpc_pkg::sample_t s_sample_ch1,
    input  sfpc_pkg::sample_t s_sample_ch2,
    input  sfpc_pkg::sample_t s_sample_ch3,
    input  sfpc_pkg::sample_t s_sample_ch4,
    input  sfpc_pkg::sample_t s_sample_ch5,
    input  sfpc_pkg::sample_t s_sample_ch6,
    input  sfpc_pkg::sample_t s_sample_ch7,
    output logic             m_valid,
    input  logic             m_ready,
    output sfpc_pkg::byte_t  m_frame_byte,
    output logic             m_frame_end
);
    import sfpc_pkg::*;

    localparam count_t MAX_COUNT = COUNT_W'(MAX_CHANNELS);

    count_t  cfg_count_reg;
    sample_t samples_reg [NUM_CH];
    count_t  n_reg;
    pos_t    pos_reg, pos_next;
    crc_t    crc_reg, crc_next;
    logic    hold_valid_reg, hold_valid_next;
    logic    m_valid_reg, m_valid_next;
    byte_t   m_byte_reg;
    logic    m_end_reg;

    count_t  n_eff;
    pos_t    twice_n;
    logic    advance;
    logic    accept;
    logic    is_data;
    logic    is_last;
    byte_t   cur_byte;
    logic [CH_IDX_W-1:0] ch_sel;
    pos_t    pos_minus1;
    sample_t cur_sample;
    crc_t    crc_stepped;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_count_reg <= COUNT_RESET;
        end else if (cfg_valid) begin
            cfg_count_reg <= cfg_channel_count;
        end
    end

    // Clamp the count into 1..MAX_CHANNELS.
    always_comb begin
        priority if (cfg_count_reg == '0) begin
            n_eff = count_t'(1);
        end else if (cfg_count_reg > MAX_COUNT) begin
            n_eff = MAX_COUNT;
        end else begin
            n_eff = cfg_count_reg;
        end
    end

    assign twice_n    = {n_reg, 1'b0};
    assign pos_minus1 = pos_reg - pos_t'(1);
    assign ch_sel     = pos_minus1[CH_IDX_W:1];
    assign cur_sample = samples_reg[ch_sel];

    always_comb begin
        is_data  = 1'b0;
        is_last  = 1'b0;
        priority if (pos_reg == '0) begin
            cur_byte = byte_t'(n_reg);
            is_data  = 1'b1;
        end else if (pos_reg <= twice_n) begin
            // odd positions carry the high byte
            cur_byte = pos_reg[0] ? cur_sample[15:8] : cur_sample[7:0];
            is_data  = 1'b1;
        end else if (pos_reg == twice_n + pos_t'(1)) begin
            cur_byte = ~crc_reg[7:0];
        end else begin
            cur_byte = ~crc_reg[15:8];
            is_last  = 1'b1;
        end
    end

    sfpc_crc_step u_crc_step (
        .crc_in  (crc_reg),
        .data_in (cur_byte),
        .crc_out (crc_stepped)
    );

    assign advance = hold_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !hold_valid_reg || (advance && is_last);
    assign accept  = s_valid && s_ready;

    always_comb begin
        pos_next        = pos_reg;
        crc_next        = crc_reg;
        hold_valid_next = hold_valid_reg;
        m_valid_next    = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (advance) begin
            m_valid_next = 1'b1;
            pos_next     = pos_reg + pos_t'(1);
            if (is_data) begin
                crc_next = crc_stepped;
            end
            if (is_last) begin
                hold_valid_next = 1'b0;
            end
        end
        if (accept) begin
            hold_valid_next = 1'b1;
            pos_next        = '0;
            crc_next        = CRC_INIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        crc_reg <= crc_next;
        if (advance) begin
            m_byte_reg <= cur_byte;
            m_end_reg  <= is_last;
        end
        if (accept) begin
            n_reg          <= n_eff;
            samples_reg[0] <= s_sample_ch0;
            samples_reg[1] <= s_sample_ch1;
            samples_reg[2] <= s_sample_ch2;
            samples_reg[3] <= s_sample_ch3;
            samples_reg[4] <= s_sample_ch4;
            samples_reg[5] <= s_sample_ch5;
            samples_reg[6] <= s_sample_ch6;
            samples_reg[7] <= s_sample_ch7;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_frame_byte = m_byte_reg;
    assign m_frame_end  = m_end_reg;

endmodule

// ===== rtl/sfpc_checker.sv =====
// Port-level checks for sample_frame_packer_crc16_unit, bound to the top.
// Depends on sfpc_pkg.
module sfpc_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input sfpc_pkg::byte_t  m_frame_byte,
    input logic             m_frame_end
);
    import sfpc_pkg::*;

    // Stalled output transaction holds.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_byte) && $stable(m_frame_end))
        else $error("output changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // A freshly taken set keeps input ready low in the cycle after it is accepted.
    a_one_set: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after taking a set");

    // An accepted end byte is followed by idle or the count byte of a new frame, never a second end byte.
    a_end_then_idle_or_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_frame_end |=> !(m_valid && m_frame_end))
        else $error("two frame end bytes in a row");

endmodule

bind sample_frame_packer_crc16_unit sfpc_checker u_sfpc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_frame_byte (m_frame_byte),
    .m_frame_end  (m_frame_end)
);

// ===== sim/sample_frame_packer_crc16_unit_tb.sv =====
// Self-checking testbench for sample_frame_packer_crc16_unit: drives conversion sets and
// channel counts, predicts every frame byte including the inverted CRC-16/MODBUS word.
// Depends on sfpc_pkg and the block's RTL only.
module sample_frame_packer_crc16_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfpc_pkg::*;

    localparam int unsigned MAX_CH      = 8;
    localparam int          SETTLE      = 4;
    localparam int          HOLDOFF     = 300;
    localparam int          STUCK_LIMIT = 2000;

    typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] sample_set_t;

    typedef struct packed {
        byte_t value;
        logic  last;
    } frame_byte_t;

    // Predicts the byte frame of each accepted set and checks the bytes as they leave.
    class frame_scoreboard;
        count_t      count_reg;
        frame_byte_t bytes_due[$];
        int          errors;

        function new();
            count_reg = COUNT_RESET;
            errors    = 0;
        endfunction

        function void set_count(count_t value);
            count_reg = value;
        endfunction

        function int pending();
            return bytes_due.size();
        endfunction

        function crc_t crc_add(crc_t crc, byte_t value);
            crc_t c;
            c = crc ^ {8'h00, value};
            for (int i = 0; i < 8; i++)
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            return c;
        endfunction

        function void push_byte(byte_t value, logic last);
            frame_byte_t fb;
            fb.value = value;
            fb.last  = last;
            bytes_due.push_back(fb);
        endfunction

        function void take_set(sample_set_t samples);
            int unsigned n;
            crc_t        crc;
            byte_t       hi;
            byte_t       lo;
            // clamp: zero counts as one channel, anything above the maximum as the maximum
            n = (count_reg == 0) ? 1 : ((count_reg > MAX_CH) ? MAX_CH : count_reg);
            crc = CRC_INIT;
            push_byte(byte_t'(n), 1'b0);
            crc = crc_add(crc, byte_t'(n));
            for (int unsigned c = 0; c < n; c++) begin
                hi = samples[c][15:8];
                lo = samples[c][7:0];
                push_byte(hi, 1'b0);
                crc = crc_add(crc, hi);
                push_byte(lo, 1'b0);
                crc = crc_add(crc, lo);
            end
            push_byte(~crc[7:0], 1'b0);
            push_byte(~crc[15:8], 1'b1);
        endfunction

        function void check_byte(byte_t got_value, logic got_last);
            frame_byte_t want;
            if (bytes_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected frame byte %02h end %0b, nothing expected",
                         $time, got_value, got_last);
                return;
            end
            want = bytes_due.pop_front();
            if (got_value !== want.value) begin
                errors++;
                $display("%0t: frame_byte expected %02h actual %02h",
                         $time, want.value, got_value);
            end
            if (got_last !== want.last) begin
                errors++;
                $display("%0t: frame_end expected %0b actual %0b", $time, want.last, got_last);
            end
        endfunction
    endclass

    logic    aclk              = 1'b0;
    logic    aresetn           = 1'b0;
    logic    cfg_valid         = 1'b0;
    logic    cfg_ready;
    count_t  cfg_channel_count = '0;
    logic    s_valid           = 1'b0;
    logic    s_ready;
    sample_t s_sample_ch0      = '0;
    sample_t s_sample_ch1      = '0;
    sample_t s_sample_ch2      = '0;
    sample_t s_sample_ch3      = '0;
    sample_t s_sample_ch4      = '0;
    sample_t s_sample_ch5      = '0;
    sample_t s_sample_ch6      = '0;
    sample_t s_sample_ch7      = '0;
    logic    m_valid;
    logic    m_ready           = 1'b0;
    byte_t   m_frame_byte;
    logic    m_frame_end;

    frame_scoreboard sb = new();

    bit          holdoff_pending = 1'b0;
    int          holdoff_left    = 0;
    logic [7:0]  ready_mask      = 8'hFF;
    int          mask_age        = 0;
    int unsigned mask_pos        = 0;
    int          stuck_cycles    = 0;

    sample_frame_packer_crc16_unit #(
        .MAX_CHANNELS(MAX_CH)
    ) uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_channel_count(cfg_channel_count),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample_ch0     (s_sample_ch0),
        .s_sample_ch1     (s_sample_ch1),
        .s_sample_ch2     (s_sample_ch2),
        .s_sample_ch3     (s_sample_ch3),
        .s_sample_ch4     (s_sample_ch4),
        .s_sample_ch5     (s_sample_ch5),
        .s_sample_ch6     (s_sample_ch6),
        .s_sample_ch7     (s_sample_ch7),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_byte     (m_frame_byte),
        .m_frame_end      (m_frame_end)
    );

    always #5 aclk = ~aclk;

    // Receiver: check each byte transaction, then choose ready for the next cycle.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_byte(m_frame_byte, m_frame_end);
        if (holdoff_pending) begin
            holdoff_left    = HOLDOFF;
            holdoff_pending = 1'b0;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            m_ready <= 1'b0;
        end else begin
            if (mask_age == 0) begin
                // one pattern in three never stalls
                ready_mask = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
                if (ready_mask == 8'h00)
                    ready_mask = 8'h01;
                mask_age = $urandom_range(16, 64);
            end
            mask_age--;
            mask_pos = (mask_pos + 1) % 8;
            m_ready <= ready_mask[mask_pos];
        end
    end

    // Watchdog: end the run once nothing has moved for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
            $display("sample_frame_packer_crc16_unit_tb: errors");
            $finish;
        end
    end

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Leave valid high afterwards; the caller lowers it.
    task automatic drive_set(input sample_set_t samples);
        s_valid      <= 1'b1;
        s_sample_ch0 <= samples[0];
        s_sample_ch1 <= samples[1];
        s_sample_ch2 <= samples[2];
        s_sample_ch3 <= samples[3];
        s_sample_ch4 <= samples[4];
        s_sample_ch5 <= samples[5];
        s_sample_ch6 <= samples[6];
        s_sample_ch7 <= samples[7];
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.take_set(samples);
    endtask

    task automatic write_count(input count_t value);
        cfg_valid         <= 1'b1;
        cfg_channel_count <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.set_count(value);
    endtask

    // Drop valid and wait for the frame queue to empty.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic send_sets(input int count, input bit no_gaps);
        sample_set_t samples;
        int          burst;
        burst = $urandom_range(1, 6);
        for (int k = 0; k < count; k++) begin
            for (int c = 0; c < NUM_CH; c++)
                samples[c] = rand_sample();
            drive_set(samples);
            burst--;
            if (burst == 0 && !no_gaps) begin
                burst = $urandom_range(1, 6);
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
        end
    endtask

    initial begin
        sample_set_t samples;
        count_t      phase_count;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // eight channels out of reset: extremes and alternating bits
        drive_set('0);
        drive_set('1);
        drive_set({NUM_CH{16'hAAAA}});
        drive_set({NUM_CH{16'h5555}});
        for (int c = 0; c < NUM_CH; c++)
            samples[c] = sample_t'(16'h0101 * (c + 1)) ^ 16'h8001;
        drive_set(samples);
        drain();

        // one channel: unused samples must not reach the frame or the CRC
        write_count(4'd1);
        drive_set({{(NUM_CH-1){16'hFFFF}}, 16'h0000});
        drive_set({{(NUM_CH-1){16'h0000}}, 16'hFFFF});
        drain();

        // zero counts as one channel
        write_count(4'd0);
        drive_set({{(NUM_CH-1){16'hFFFF}}, 16'h1234});
        drive_set('0);
        drain();

        // above the maximum clamps to eight
        write_count(4'd15);
        drive_set('1);
        for (int c = 0; c < NUM_CH; c++)
            samples[c] = rand_sample();
        drive_set(samples);
        drain();

        write_count(4'd9);
        drive_set({NUM_CH/2{32'hAAAA5555}});
        drain();

        write_count(4'd4);
        for (int c = 0; c < NUM_CH; c++)
            samples[c] = sample_t'($urandom);
        drive_set(samples);
        drive_set('1);
        drain();

        write_count(4'd8);
        drive_set('0);
        drain();

        // random phases, each with its own count; phase 5 holds the receiver off
        for (int p = 0; p < 10; p++) begin
            case (p)
                0:       phase_count = 4'd1;
                1:       phase_count = 4'd8;
                2:       phase_count = 4'd0;
                3:       phase_count = 4'd15;
                default: phase_count = count_t'($urandom_range(0, 15));
            endcase
            write_count(phase_count);
            if (p == 5) begin
                holdoff_pending = 1'b1;
                send_sets(8, 1'b1);
            end else begin
                send_sets(11, 1'b0);
            end
            drain();
        end

        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("sample_frame_packer_crc16_unit_tb: clean");
        else
            $display("sample_frame_packer_crc16_unit_tb: errors");
        $finish;
    end

endmodule
